// ===== rtl/core/u8d_pkg.sv =====
// shared types and constants of the utf-8 decoder
package u8d_pkg;

  localparam int unsigned U8D_MAX_RES    = 3;
  localparam int unsigned U8D_FIFO_DEPTH = 4;

  localparam logic [15:0] ESC_BASE  = 16'hDC00;
  localparam logic [15:0] ESC_LEAD3 = 16'hDCE0;
  localparam logic [15:0] ESC_CONT  = 16'hDC80;
  localparam logic [15:0] ESC_LEAD2 = 16'hDCC0;

  typedef struct packed {
    logic [1:0]                         cnt;
    logic [U8D_MAX_RES-1:0][15:0]       cp;
    logic [U8D_MAX_RES-1:0]             inv;
  } res_bundle_t;

endpackage

// ===== rtl/core/u8d_front.sv =====
// front end: classifies each byte, tracks the sequence state, builds the result bundle
module u8d_front import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  output logic        push_o,
  output res_bundle_t bundle_o
);

  logic [1:0]  awaited_q, awaited_d;
  logic [1:0]  seen_q, seen_d;
  logic [15:0] partial_q, partial_d;
  logic        lead3_q, lead3_d;

  logic [1:0]  fl_cnt, slot, aw_dec;
  logic [15:0] fl_cp0, fl_cp1, cont_part, own_cp;
  logic        use_flush, own_v, own_inv;

  assign aw_dec    = awaited_q - 2'd1;
  assign cont_part = {partial_q[9:0], in_byte_i[5:0]};

  // escapes of an unfinished sequence
  always_comb begin
    fl_cnt = 2'd0;
    fl_cp0 = ESC_LEAD3 | {6'b0, partial_q[15:6]};
    fl_cp1 = ESC_CONT | {10'b0, partial_q[5:0]};
    if (awaited_q != 2'd0) begin
      if (seen_q >= 2'd2) begin
        fl_cnt = 2'd2;
      end else if (seen_q == 2'd1) begin
        fl_cnt = 2'd1;
        fl_cp0 = lead3_q ? (ESC_LEAD3 | {12'b0, partial_q[3:0]})
                         : (ESC_LEAD2 | {11'b0, partial_q[4:0]});
      end
    end
  end

  always_comb begin
    awaited_d = awaited_q;
    seen_d    = seen_q;
    partial_d = partial_q;
    lead3_d   = lead3_q;
    use_flush = 1'b0;
    own_v     = 1'b0;
    own_cp    = ESC_BASE | {8'h00, in_byte_i};
    own_inv   = 1'b1;
    case (in_byte_i) inside
      [8'h00:8'h7F]: begin
        use_flush = 1'b1;
        awaited_d = 2'd0;
        own_v     = 1'b1;
        own_cp    = {8'h00, in_byte_i};
        own_inv   = 1'b0;
      end
      [8'h80:8'hBF]: begin
        if (awaited_q == 2'd0) begin
          seen_d = 2'd0;
          own_v  = 1'b1;
        end else begin
          awaited_d = aw_dec;
          seen_d    = seen_q + 2'd1;
          partial_d = cont_part;
          if (aw_dec == 2'd0) begin
            own_v   = 1'b1;
            own_cp  = cont_part;
            own_inv = 1'b0;
          end
        end
      end
      [8'hC0:8'hDF]: begin
        use_flush = 1'b1;
        awaited_d = 2'd1;
        seen_d    = 2'd1;
        partial_d = {11'b0, in_byte_i[4:0]};
        lead3_d   = 1'b0;
      end
      [8'hE0:8'hEF]: begin
        use_flush = 1'b1;
        awaited_d = 2'd2;
        seen_d    = 2'd1;
        partial_d = {12'b0, in_byte_i[3:0]};
        lead3_d   = 1'b1;
      end
      default: begin
        use_flush = 1'b1;
        awaited_d = 2'd0;
        own_v     = 1'b1;
      end
    endcase
  end

  // pack flush escapes first, then the byte's own result
  always_comb begin
    bundle_o = '0;
    slot     = use_flush ? fl_cnt : 2'd0;
    if (use_flush) begin
      bundle_o.cp[0]  = fl_cp0;
      bundle_o.cp[1]  = fl_cp1;
      bundle_o.inv[0] = 1'b1;
      bundle_o.inv[1] = 1'b1;
    end
    if (own_v) begin
      bundle_o.cp[slot]  = own_cp;
      bundle_o.inv[slot] = own_inv;
    end
    bundle_o.cnt = slot + {1'b0, own_v};
  end

  assign push_o = accept_i && (bundle_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_q <= 2'd0;
      seen_q    <= 2'd0;
      partial_q <= 16'd0;
      lead3_q   <= 1'b0;
    end else if (accept_i) begin
      awaited_q <= awaited_d;
      seen_q    <= seen_d;
      partial_q <= partial_d;
      lead3_q   <= lead3_d;
    end
  end

endmodule

// ===== rtl/core/u8d_fifo.sv =====
// bundle queue between front end and output sequencer
module u8d_fifo import u8d_pkg::*; #(
  parameter int unsigned Depth = U8D_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_bundle_t wdata_i,
  output logic        full_o,
  output logic        valid_o,
  output res_bundle_t rdata_o,
  input  logic        pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_bundle_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/core/u8d_back.sv =====
// output sequencer: walks the results of the head bundle one per cycle while the output is not stalled
module u8d_back import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  res_bundle_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_point_o,
  output logic        is_invalid_o,
  output logic        is_last_o
);

  logic [1:0] idx_q;
  logic       take;

  assign out_valid_o  = head_valid_i;
  assign code_point_o = head_i.cp[idx_q];
  assign is_invalid_o = head_i.inv[idx_q];
  assign is_last_o    = (idx_q == head_i.cnt - 2'd1);
  assign take         = out_valid_o && !out_stall_i;
  assign pop_o        = take && is_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= is_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < head_i.cnt))
    else $error("result index beyond bundle");

  a_no_empty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_i.cnt != 2'd0))
    else $error("empty bundle in queue");

endmodule

// ===== rtl/core/utf8_decoder_with_invalid_escape.sv =====
// top level of the utf-8 decoder with escaping of invalid bytes
// with the queue empty, the first result of a byte is offered in the cycle after the byte is accepted
// throughput: one byte per cycle while the queue is not full; the k results of a byte are offered in turn
// a FifoDepth-entry bundle queue absorbs flushes; input stalls only when it is full
// reset clears sequence state, queue pointers and the result index; queue data is not reset
module utf8_decoder_with_invalid_escape import u8d_pkg::*; #(
  parameter int unsigned FifoDepth = U8D_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_point_o,
  output logic        is_invalid_o,
  output logic        is_last_o
);

  logic        accept, push, full, head_valid, pop;
  res_bundle_t wbundle, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  u8d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .push_o    (push),
    .bundle_o  (wbundle)
  );

  u8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .full_o  (full),
    .valid_o (head_valid),
    .rdata_o (head),
    .pop_i   (pop)
  );

  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .is_invalid_o (is_invalid_o),
    .is_last_o    (is_last_o)
  );

endmodule
